[rtl/tccs_pkg.sv]
// Shared constants and types for the text console with cursor and scroll.
// No dependencies; used by the console top level.
`timescale 1ns / 1ps

package tccs_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    // Stream payload widths (padded to whole bytes)
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Register reset and control characters
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam int                TAB_STOP     = 8;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CELL_W-1:0] cell_t;

endpackage

[rtl/tccs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; instanced by the console top level for the screen cells.
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/text_console_cursor_scroll.sv]
// Text console top level: cursor control, scroll sequencer and result register.
// Depends on tccs_pkg and tccs_ram (screen cell memory).
`timescale 1ns / 1ps

// Character-cell console of ROWS x COLUMNS 16-bit cells (attribute high byte,
// character low byte) with a cursor.
// Input stream s_axis: tuser = mode (0 put a character, 1 read one cell),
//   tdata = char_code, read_row, read_col from the low bit up.
// Output stream m_axis: one transaction per input transaction, carrying the
//   cursor after the item, the cell read (zero for a put) and the scroll flag.
// Config: cfg_wr_en / cfg_wr_data write the text attribute; write it only
//   while no transaction is in flight.
// Sequence: a put without scroll shows its result in the cycle after acceptance;
//   a read passes through ST_READ for one memory read. A put that finds a scroll
//   pending first copies (ROWS-1)*COLUMNS cells one per cycle through the
//   single cell RAM, then blanks COLUMNS cells, then applies the character.
// Throughput: one item per cycle for puts without scroll when the result is
//   taken at once, while no item is taken in ST_READ; the result register lets
//   the next item be accepted in the cycle its predecessor's result is taken.
// Reset: the cursor goes to row 0 column 0, the attribute to 15, and the
//   cell RAM is swept to zero one cell per cycle, with s_axis_tready low
//   during the sweep.
// Stall: while m_axis_tready is low a result holds, and no new item is taken.
module text_console_cursor_scroll (
    input  logic                                clk,
    input  logic                                rst_n,
    // Attribute register write
    input  logic                                cfg_wr_en,
    input  logic [tccs_pkg::ATTR_W-1:0]         cfg_wr_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tccs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // char_code, read_row, read_col
    input  logic                                s_axis_tuser,  // mode
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tccs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // cursor_col, cursor_row,
                                                               // read_data, scrolled
);

    localparam int ADDR_W = tccs_pkg::ADDR_W;
    localparam int COL_W  = tccs_pkg::COL_W;
    localparam int ROW_W  = tccs_pkg::ROW_W;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(tccs_pkg::CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(tccs_pkg::COPY_CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_START = ADDR_W'(tccs_pkg::COPY_CELLS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(tccs_pkg::COLUMNS);
    localparam logic [COL_W:0]    COL_LIMIT  = (COL_W + 1)'(tccs_pkg::COLUMNS);
    localparam logic [COL_W:0]    TAB_STEP   = (COL_W + 1)'(tccs_pkg::TAB_STOP);
    localparam logic [COL_W:0]    TAB_MASK   = ~((COL_W + 1)'(tccs_pkg::TAB_STOP - 1));
    localparam logic [ROW_W-1:0]  ROW_LIMIT  = ROW_W'(tccs_pkg::ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(tccs_pkg::ROWS - 1);

    // Input fields
    logic                        in_mode;
    logic [tccs_pkg::CHAR_W-1:0] in_char;
    logic [ROW_W-1:0]            in_row;
    logic [COL_W-1:0]            in_col;

    assign in_mode = s_axis_tuser;
    assign in_char = s_axis_tdata[7:0];
    assign in_row  = s_axis_tdata[12:8];
    assign in_col  = s_axis_tdata[19:13];

    // Registers
    logic [2:0]                  state_reg, state_next;
    tccs_pkg::addr_t             scan_reg, scan_next;
    tccs_pkg::addr_t             pend_addr_reg;
    logic                        pend_valid_reg;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            line_reg, line_next;
    logic [tccs_pkg::ATTR_W-1:0] attr_reg;
    logic [tccs_pkg::CHAR_W-1:0] char_reg;
    logic                        rd_ok_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [tccs_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // RAM ports
    logic            ram_we;
    tccs_pkg::addr_t ram_waddr;
    tccs_pkg::cell_t ram_wdata;
    tccs_pkg::addr_t ram_raddr;
    tccs_pkg::cell_t ram_rdata;

    logic accept;
    logic out_free;

    // Put evaluation
    logic [tccs_pkg::CHAR_W-1:0] put_char;
    logic [COL_W-1:0]            put_col;
    logic [ROW_W-1:0]            put_line;
    logic                        put_we;
    logic                        put_wrap;
    logic [COL_W:0]              col_ext;
    logic [COL_W:0]              col_tab;
    logic [COL_W:0]              col_inc;
    tccs_pkg::addr_t             cursor_addr;
    tccs_pkg::addr_t             read_addr;
    logic                        read_in_range;
    tccs_pkg::cell_t             blank_cell;

    tccs_ram #(
        .WIDTH (tccs_pkg::CELL_W),
        .DEPTH (tccs_pkg::CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign blank_cell    = {attr_reg, tccs_pkg::CH_BLANK};
    assign cursor_addr   = ADDR_W'(ADDR_W'(line_reg) * ROW_STRIDE) + ADDR_W'(col_reg);
    assign read_addr     = ADDR_W'(ADDR_W'(in_row) * ROW_STRIDE) + ADDR_W'(in_col);
    assign read_in_range = (in_row < ROW_LIMIT) && ((COL_W + 1)'(in_col) < COL_LIMIT);

    // Work out the cursor move and cell write for one put character
    always_comb
    begin
        put_char = (state_reg == ST_FINISH) ? char_reg : in_char;
        col_ext  = {1'b0, col_reg};
        col_tab  = (col_ext + TAB_STEP) & TAB_MASK;
        col_inc  = col_ext + (COL_W + 1)'(1);
        put_col  = col_reg;
        put_line = line_reg;
        put_we   = 1'b0;
        put_wrap = 1'b0;
        case (put_char)
            tccs_pkg::CH_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    put_col = col_reg - COL_W'(1);
                end
            end
            tccs_pkg::CH_TAB:
            begin
                if (col_tab >= COL_LIMIT)
                begin
                    put_wrap = 1'b1;
                end
                else
                begin
                    put_col = col_tab[COL_W-1:0];
                end
            end
            tccs_pkg::CH_NEWLINE:
            begin
                put_wrap = 1'b1;
            end
            tccs_pkg::CH_RETURN:
            begin
                put_col = '0;
            end
            default:
            begin
                put_we = 1'b1;
                if (col_inc >= COL_LIMIT)
                begin
                    put_wrap = 1'b1;
                end
                else
                begin
                    put_col = col_inc[COL_W-1:0];
                end
            end
        endcase
        if (put_wrap)
        begin
            put_col = '0;
            if (line_reg < ROW_LIMIT)
            begin
                put_line = line_reg + ROW_W'(1);
            end
        end
    end

    // Sequence the clear sweep, items, scroll copy and blanking
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cursor_addr;
        ram_wdata      = {attr_reg, put_char};
        ram_raddr      = read_addr;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = '0;
                scan_next = scan_reg + ADDR_W'(1);
                if (scan_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode)
                    begin
                        state_next = ST_READ;
                    end
                    else if (line_reg >= ROW_LIMIT)
                    begin
                        state_next = ST_SCROLL;
                        scan_next  = '0;
                        line_next  = ROW_LAST;
                    end
                    else
                    begin
                        ram_we         = put_we;
                        col_next       = put_col;
                        line_next      = put_line;
                        out_valid_next = 1'b1;
                        out_data_next  = {3'b000, 1'b0, 16'h0000, put_line, put_col};
                    end
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = {3'b000, 1'b0, (rd_ok_reg ? ram_rdata : 16'h0000),
                                  line_reg, col_reg};
            end
            ST_SCROLL:
            begin
                // Read one row below, write the previous read one row up
                ram_raddr = scan_reg + ROW_STRIDE;
                ram_we    = pend_valid_reg;
                ram_waddr = pend_addr_reg;
                ram_wdata = ram_rdata;
                if (scan_reg == COPY_LAST)
                begin
                    state_next = ST_BLANK;
                    scan_next  = COPY_START;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_BLANK:
            begin
                ram_we = 1'b1;
                if (pend_valid_reg)
                begin
                    // Drain the last copied cell first
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                else
                begin
                    ram_waddr = scan_reg;
                    ram_wdata = blank_cell;
                    scan_next = scan_reg + ADDR_W'(1);
                    if (scan_reg == LAST_CELL)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                ram_we         = put_we;
                col_next       = put_col;
                line_next      = put_line;
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = {3'b000, 1'b1, 16'h0000, put_line, put_col};
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
            col_reg        <= '0;
            line_reg       <= '0;
            attr_reg       <= tccs_pkg::ATTR_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= (state_reg == ST_SCROLL);
            col_reg        <= col_next;
            line_reg       <= line_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= scan_reg;
        out_data_reg  <= out_data_next;
        if (accept)
        begin
            char_reg  <= in_char;
            rd_ok_reg <= read_in_range;
        end
    end

    // Cursor column stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (COL_W + 1)'(col_reg) < COL_LIMIT)
        else $error("cursor column left the screen");

    // Cursor row never passes the pending-scroll row
    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg <= ROW_LIMIT)
        else $error("cursor row beyond pending-scroll row");

    // A put without scroll delivers its result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_mode && (line_reg < ROW_LIMIT)) |=> out_valid_reg)
        else $error("put result missing");

    // No item is taken while a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !accept)
        else $error("item accepted over stalled result");

endmodule
